// ===== src/bre_pkg.sv =====
// Shared types and constants for the bitmap range engine.
`timescale 1ns / 1ps

package bre_pkg;

   localparam int DEF_WORD_COUNT = 64;

   localparam int WORD_BITS = 64;
   localparam int OFF_W     = 6;
   localparam int OP_W      = 3;
   localparam int START_W   = 12;
   localparam int LEN_W     = 13;
   localparam int COUNT_W   = 13;
   localparam int POP_W     = 7;

   typedef enum logic [OP_W-1:0] {
      OP_SET    = 3'd0,
      OP_CLEAR  = 3'd1,
      OP_INVERT = 3'd2,
      OP_COUNT  = 3'd3,
      OP_TEST   = 3'd4
   } op_type;

   // control for one pass of the word unit
   typedef struct packed {
      op_type           op;
      logic [OFF_W-1:0] lo_off;
      logic [OFF_W-1:0] hi_off;
   } word_ctl_type;

endpackage

// ===== src/bre_mem.sv =====
// Bitmap word store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module bre_mem
   import bre_pkg::*;
#(
   parameter int WORD_COUNT = DEF_WORD_COUNT,
   parameter int IDX_W      = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_ff [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bre_word_unit.sv =====
// Shared word unit: range mask, set/clear/invert, popcount and bit test.
`timescale 1ns / 1ps

module bre_word_unit
   import bre_pkg::*;
(
   input  word_ctl_type         ctl,
   input  logic [WORD_BITS-1:0] rd_word,
   output logic [WORD_BITS-1:0] wr_word,
   output logic [POP_W-1:0]     pop,
   output logic                 bit_out
);

   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] hit;
   logic [3:0]           byte_pop [8];

   assign mask = ({WORD_BITS{1'b1}} << ctl.lo_off)
               & ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - ctl.hi_off));
   assign hit  = rd_word & mask;

   always_comb begin
      case (ctl.op)
         OP_SET:    wr_word = rd_word | mask;
         OP_CLEAR:  wr_word = rd_word & ~mask;
         OP_INVERT: wr_word = rd_word ^ mask;
         default:   wr_word = rd_word;
      endcase
   end

   // two-level popcount: per byte, then across bytes
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         byte_pop[b] = 4'd0;
         for (int i = 0; i < 8; i++) begin
            byte_pop[b] = byte_pop[b] + 4'(hit[b*8+i]);
         end
      end
   end

   always_comb begin
      pop = '0;
      for (int b = 0; b < 8; b++) begin
         pop = pop + POP_W'(byte_pop[b]);
      end
   end

   assign bit_out = rd_word[ctl.lo_off];

endmodule

// ===== src/bitmap_range_engine.sv =====
// Bitmap range engine top level: request sequencer, word store and word unit.
`timescale 1ns / 1ps

// Keeps a bitmap of WORD_COUNT 64-bit words; bit b is bit b%64 of word b/64.
// Each request word sets, clears, inverts or counts the bits of
// [start_bit, start_bit+range_length), clipped at the end of the map, or tests
// the bit at start_bit; every request returns exactly one response word.
// After reset a clearing pass zeroes the store, one word a cycle, so the
// block takes no request until the pass is done. A range request reads each
// word that it spans from the store once and passes it through the shared
// word unit; set, clear and invert write it back, and the read of the next
// word overlaps the write-back of the current one. A test reads one word; an
// empty range, a test past the end or an unused operation code reads none.
// Requests are handled one at a time; a finished response sits in an output
// register, so the next request is taken while the response still waits for
// rsp_ready.
module bitmap_range_engine
   import bre_pkg::*;
#(
   parameter int WORD_COUNT = DEF_WORD_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [START_W-1:0] req_start_bit,
   input  logic [LEN_W-1:0]   req_range_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COUNT_W-1:0] rsp_set_count,
   output logic               rsp_bit_value
);

   localparam int TOTAL_BITS = WORD_COUNT * WORD_BITS;
   localparam int TOTAL_W    = $clog2(TOTAL_BITS + 1);
   localparam int SUM_W      = LEN_W + 1;
   localparam int CMP_W      = (TOTAL_W > SUM_W) ? TOTAL_W : SUM_W;
   localparam int W_W        = CMP_W - OFF_W;
   localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   op_type               op_ff, op_in;
   logic [OFF_W-1:0]     start_off_ff, start_off_in;
   logic [OFF_W-1:0]     end_off_ff, end_off_in;
   logic [W_W-1:0]       first_w_ff, first_w_in;
   logic [W_W-1:0]       last_w_ff, last_w_in;
   logic [W_W-1:0]       rd_w_ff, rd_w_in;
   logic                 reading_ff, reading_in;
   logic                 pend_ff, pend_in;
   logic [W_W-1:0]       pend_w_ff, pend_w_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_bit_ff, rsp_bit_in;

   // request decode
   logic [CMP_W-1:0]     sum_bits, end_bits, last_bit, start_ext;
   logic                 range_ok, test_ok;
   op_type               req_op;

   // store and word unit
   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data, unit_word;
   logic [POP_W-1:0]     unit_pop;
   logic                 unit_bit;
   word_ctl_type         unit_ctl;

   assign req_op    = op_type'(req_operation);
   assign start_ext = CMP_W'(req_start_bit);
   assign sum_bits  = start_ext + CMP_W'(req_range_length);
   assign end_bits  = (sum_bits > CMP_W'(TOTAL_BITS)) ? CMP_W'(TOTAL_BITS) : sum_bits;
   assign last_bit  = end_bits - CMP_W'(1);
   assign range_ok  = (req_op == OP_SET || req_op == OP_CLEAR || req_op == OP_INVERT
                       || req_op == OP_COUNT) && (start_ext < end_bits);
   assign test_ok   = (req_op == OP_TEST) && (start_ext < CMP_W'(TOTAL_BITS));

   // offsets of the word in the write-back stage
   assign unit_ctl.op     = op_ff;
   assign unit_ctl.lo_off = (pend_w_ff == first_w_ff) ? start_off_ff : '0;
   assign unit_ctl.hi_off = (pend_w_ff == last_w_ff) ? end_off_ff : OFF_W'(WORD_BITS - 1);

   bre_word_unit u_unit (
      .ctl     (unit_ctl),
      .rd_word (rd_data),
      .wr_word (unit_word),
      .pop     (unit_pop),
      .bit_out (unit_bit)
   );

   bre_mem #(
      .WORD_COUNT (WORD_COUNT),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // store port control
   always_comb begin
      rd_en   = (state_ff == ST_RUN) && reading_ff;
      rd_addr = rd_w_ff[IDX_W-1:0];
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = (state_ff == ST_RUN) && pend_ff
                   && (op_ff == OP_SET || op_ff == OP_CLEAR || op_ff == OP_INVERT);
         wr_addr = pend_w_ff[IDX_W-1:0];
         wr_data = unit_word;
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      start_off_in = start_off_ff;
      end_off_in   = end_off_ff;
      first_w_in   = first_w_ff;
      last_w_in    = last_w_ff;
      rd_w_in      = rd_w_ff;
      reading_in   = reading_ff;
      pend_in      = 1'b0;
      pend_w_in    = pend_w_ff;
      count_in     = count_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_bit_in   = rsp_bit_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = req_op;
               start_off_in = req_start_bit[OFF_W-1:0];
               end_off_in   = last_bit[OFF_W-1:0];
               first_w_in   = W_W'(req_start_bit[START_W-1:OFF_W]);
               last_w_in    = last_bit[CMP_W-1:OFF_W];
               rd_w_in      = W_W'(req_start_bit[START_W-1:OFF_W]);
               count_in     = '0;
               bit_in       = 1'b0;
               if (test_ok) begin
                  last_w_in  = W_W'(req_start_bit[START_W-1:OFF_W]);
                  reading_in = 1'b1;
                  state_in   = ST_RUN;
               end else if (range_ok) begin
                  reading_in = 1'b1;
                  state_in   = ST_RUN;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_RUN: begin
            if (reading_ff) begin
               pend_in    = 1'b1;
               pend_w_in  = rd_w_ff;
               rd_w_in    = rd_w_ff + W_W'(1);
               reading_in = (rd_w_ff != last_w_ff);
            end
            if (pend_ff) begin
               if (op_ff == OP_COUNT) begin
                  count_in = count_ff + COUNT_W'(unit_pop);
               end
               if (op_ff == OP_TEST) begin
                  bit_in = unit_bit;
               end
               if (pend_w_ff == last_w_ff) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_bit_in   = bit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         reading_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         reading_ff   <= reading_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      start_off_ff <= start_off_in;
      end_off_ff   <= end_off_in;
      first_w_ff   <= first_w_in;
      last_w_ff    <= last_w_in;
      rd_w_ff      <= rd_w_in;
      pend_w_ff    <= pend_w_in;
      count_ff     <= count_in;
      bit_ff       <= bit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bit_ff   <= rsp_bit_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_set_count = rsp_count_ff;
   assign rsp_bit_value = rsp_bit_ff;

endmodule
